// ----- hdl/tad_pkg.sv -----
`timescale 1ns / 1ps
package tad_pkg;
    localparam int AngCount = 24;
    localparam int AccW = 28;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_CENTER = 2'd1;
    localparam logic [1:0] REG_TOL    = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // latch sample, shift windows, start sums
        logic sq_step;     // one step of the root units
        logic cordic_init; // set up vector from h and fz
        logic cordic_step; // one CORDIC rotation
        logic finish;      // compute tilt / leaned into result register
    } tad_cmd_t;

    typedef struct packed {
        logic sq_done;
        logic cordic_done;
    } tad_sts_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic [AccW-1:0] ang_lut(input logic [4:0] i);
        logic [AccW-1:0] r;
        case (i)
            5'd0: r = 28'd2949120;  5'd1: r = 28'd1740967;
            5'd2: r = 28'd919879;   5'd3: r = 28'd466945;
            5'd4: r = 28'd234379;   5'd5: r = 28'd117304;
            5'd6: r = 28'd58666;    5'd7: r = 28'd29335;
            5'd8: r = 28'd14668;    5'd9: r = 28'd7334;
            5'd10: r = 28'd3667;    5'd11: r = 28'd1833;
            5'd12: r = 28'd917;     5'd13: r = 28'd458;
            5'd14: r = 28'd229;     5'd15: r = 28'd115;
            5'd16: r = 28'd57;      5'd17: r = 28'd29;
            5'd18: r = 28'd14;      5'd19: r = 28'd7;
            5'd20: r = 28'd4;       5'd21: r = 28'd2;
            5'd22: r = 28'd1;       default: r = 28'd0;
        endcase
        return r;
    endfunction
endpackage

// ----- hdl/tilt_angle_detector_core.sv -----
`timescale 1ns / 1ps
// Tilt detector: converts one three-axis accelerometer sample per transaction,
// filters each axis over a 5-sample weighted window, and reports the angle to Z
// (whole degrees), the raw magnitude and a leaned flag. Each sample passes through
// the 20-digit square root (one digit a cycle) and then the CORDIC rotator (one
// rotation a cycle) before the finish step. A finished result sits
// in the output register; a new sample is taken once the previous one is done.
module tilt_angle_detector_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // x_word, y_word, z_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // x_accel, y_accel, z_accel, magnitude, tilt_degrees
    output logic        m_tuser,   // leaned
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);
    tad_pkg::tad_cmd_t cmd;
    tad_pkg::tad_sts_t sts;
    logic busy, out_valid_reg, in_fire;
    logic enable_reg;
    logic signed [8:0] center_reg;
    logic [7:0] tol_reg;
    logic [56:0] result;

    assign cfg_ready = aresetn;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1; center_reg <= '0; tol_reg <= 8'd15;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tad_pkg::REG_ENABLE: enable_reg <= cfg_data[0];
                tad_pkg::REG_CENTER: center_reg <= cfg_data;
                tad_pkg::REG_TOL:    tol_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign s_tready = aresetn && !busy;
    assign in_fire = s_tvalid && s_tready;

    tad_ctrl u_ctrl (
        .aclk, .aresetn, .in_fire,
        .out_free(!out_valid_reg || m_tready), .sts, .busy, .cmd
    );

    tad_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .x_word(s_tdata[15:0]), .y_word(s_tdata[31:16]), .z_word(s_tdata[47:32]),
        .detect_enable(enable_reg), .center_angle(center_reg), .tolerance(tol_reg),
        .result
    );

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else if (cmd.finish) out_valid_reg <= 1'b1;
        else if (m_tready) out_valid_reg <= 1'b0;
    end
    assign m_tvalid = out_valid_reg;
    assign m_tdata = result[55:0];
    assign m_tuser = result[56];
endmodule

// ----- hdl/tad_ctrl.sv -----
`timescale 1ns / 1ps
module tad_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  logic             out_free,
    input  tad_pkg::tad_sts_t sts,
    output logic             busy,
    output tad_pkg::tad_cmd_t cmd
);
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SQRT   = 5'b00010,
        ST_INIT   = 5'b00100,
        ST_CORDIC = 5'b01000,
        ST_FIN    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Sequencer: load, roots, CORDIC, finish
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cmd.load = 1'b1;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                cmd.sq_step = 1'b1;
                if (sts.sq_done) state_next = ST_INIT;
            end
            ST_INIT: begin
                cmd.cordic_init = 1'b1;
                state_next = ST_CORDIC;
            end
            ST_CORDIC: begin
                cmd.cordic_step = 1'b1;
                if (sts.cordic_done) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end
endmodule

// ----- hdl/tad_datapath.sv -----
`timescale 1ns / 1ps
module tad_datapath #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tad_pkg::tad_cmd_t cmd,
    output tad_pkg::tad_sts_t sts,
    input  logic [15:0]       x_word,
    input  logic [15:0]       y_word,
    input  logic [15:0]       z_word,
    input  logic              detect_enable,
    input  logic signed [8:0] center_angle,
    input  logic [7:0]        tolerance,
    output logic [56:0]       result
);
    localparam int Steps = (CORDIC_STEPS < tad_pkg::AngCount) ? CORDIC_STEPS
                                                               : tad_pkg::AngCount;
    localparam int AccW = tad_pkg::AccW;
    localparam int VW = 34;  // CORDIC vector width, with growth headroom

    logic signed [11:0] xw_reg [5], yw_reg [5], zw_reg [5];
    logic signed [11:0] ax_reg, ay_reg, az_reg;
    logic signed [11:0] fx_reg, fy_reg, fz_reg;
    logic [23:0] msq_reg;      // magnitude root remainder source
    logic [11:0] mres_reg;
    logic [23:0] mrem_reg;
    logic [39:0] hsq_reg;      // (fx^2+fy^2) << 16
    logic [19:0] hres_reg;
    logic [39:0] hrem_reg;
    logic [4:0]  sq_cnt_reg;
    logic        sq_phase_reg; // 0: squaring, 1: root digits
    logic signed [VW-1:0] cx_reg, cy_reg;
    logic signed [AccW-1:0] acc_reg;
    logic [4:0]  ci_reg;
    logic        zero_reg;
    logic [56:0] res_reg;

    // Axis conversion: negate, most negative maps to 0
    function automatic logic signed [11:0] conv(input logic [15:0] w);
        logic signed [11:0] r;
        r = w[15:4];
        if (r == -12'sd2048) return 12'sd0;
        return -r;
    endfunction

    function automatic logic signed [11:0] wsum(input logic signed [11:0] a,
        input logic signed [11:0] b, input logic signed [11:0] c,
        input logic signed [11:0] d, input logic signed [11:0] e);
        logic signed [15:0] s;
        logic [15:0] m;
        logic [31:0] q;
        s = 16'(4 * a) + 16'(2 * b) + 16'(2 * c) + 16'(d) + 16'(e);
        m = s[15] ? 16'(-s) : s;
        q = 32'(m) * 32'd52429;  // divide by 10, exact for any 16-bit m
        q = q >> 19;
        return s[15] ? -12'(q) : 12'(q);
    endfunction

    logic signed [11:0] nx, ny, nz;
    assign nx = conv(x_word);
    assign ny = conv(y_word);
    assign nz = conv(z_word);

    // Root digit steps
    logic [25:0] mtrial;
    logic [41:0] htrial;
    assign mtrial = {mrem_reg, msq_reg[23:22]} - {12'd0, mres_reg, 2'b01};
    assign htrial = {hrem_reg, hsq_reg[39:38]} - {20'd0, hres_reg, 2'b01};

    // CORDIC shifted terms (arithmetic shift is floor)
    logic signed [VW-1:0] dx, dy;
    assign dx = cx_reg >>> ci_reg;
    assign dy = cy_reg >>> ci_reg;

    // Band check
    logic signed [10:0] lo, hi, t;
    logic in_band;
    always_comb begin
        lo = 11'(center_angle) - 11'(signed'({1'b0, tolerance}));
        hi = 11'(center_angle) + 11'(signed'({1'b0, tolerance}));
        if (lo < -11'sd180) lo = lo + 11'sd360;
        if (hi > 11'sd180) hi = hi - 11'sd360;
        if (acc_reg < 0) t = 11'sd0;
        else if ((acc_reg >>> 16) > 180) t = 11'sd180;
        else t = 11'(acc_reg >>> 16);
        if (lo <= hi) in_band = (t >= lo) && (t <= hi);
        else in_band = (t >= lo) || (t <= hi);
    end

    assign sts.sq_done = sq_phase_reg && (sq_cnt_reg == 5'd19);
    assign sts.cordic_done = (ci_reg == 5'(Steps - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 5; i++) begin
                xw_reg[i] <= '0; yw_reg[i] <= '0; zw_reg[i] <= '0;
            end
        end else if (cmd.load) begin
            for (int i = 0; i < 4; i++) begin
                xw_reg[i] <= xw_reg[i+1]; yw_reg[i] <= yw_reg[i+1];
                zw_reg[i] <= zw_reg[i+1];
            end
            xw_reg[4] <= nx; yw_reg[4] <= ny; zw_reg[4] <= nz;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ax_reg <= nx; ay_reg <= ny; az_reg <= nz;
            fx_reg <= wsum(xw_reg[1], xw_reg[2], xw_reg[3], xw_reg[4], nx);
            fy_reg <= wsum(yw_reg[1], yw_reg[2], yw_reg[3], yw_reg[4], ny);
            fz_reg <= wsum(zw_reg[1], zw_reg[2], zw_reg[3], zw_reg[4], nz);
            sq_phase_reg <= 1'b0;
            sq_cnt_reg <= '0;
        end else if (cmd.sq_step) begin
            if (!sq_phase_reg) begin
                // squares summed first for ax, ay and fx, then for az and fy
                if (sq_cnt_reg == 5'd0) begin
                    msq_reg <= 24'(ax_reg * ax_reg) + 24'(ay_reg * ay_reg);
                    hsq_reg <= {24'(fx_reg * fx_reg), 16'd0};
                    sq_cnt_reg <= 5'd1;
                end else begin
                    msq_reg <= msq_reg + 24'(az_reg * az_reg);
                    hsq_reg <= {hsq_reg[39:16] + 24'(fy_reg * fy_reg), 16'd0};
                    sq_phase_reg <= 1'b1;
                    sq_cnt_reg <= '0;
                    mres_reg <= '0; mrem_reg <= '0;
                    hres_reg <= '0; hrem_reg <= '0;
                end
            end else begin
                if (sq_cnt_reg < 5'd12) begin
                    msq_reg <= {msq_reg[21:0], 2'b00};
                    if (!mtrial[25]) begin
                        mrem_reg <= mtrial[23:0]; mres_reg <= {mres_reg[10:0], 1'b1};
                    end else begin
                        mrem_reg <= {mrem_reg[21:0], msq_reg[23:22]};
                        mres_reg <= {mres_reg[10:0], 1'b0};
                    end
                end
                hsq_reg <= {hsq_reg[37:0], 2'b00};
                if (!htrial[41]) begin
                    hrem_reg <= htrial[39:0]; hres_reg <= {hres_reg[18:0], 1'b1};
                end else begin
                    hrem_reg <= {hrem_reg[37:0], hsq_reg[39:38]};
                    hres_reg <= {hres_reg[18:0], 1'b0};
                end
                sq_cnt_reg <= sq_cnt_reg + 5'd1;
            end
        end
    end

    // CORDIC vectoring
    always_ff @(posedge aclk) begin
        if (cmd.cordic_init) begin
            ci_reg <= '0;
            zero_reg <= (fx_reg == 0) && (fy_reg == 0) && (fz_reg == 0);
            if (fz_reg < 0) begin
                cx_reg <= VW'(hres_reg);
                cy_reg <= -(VW'(fz_reg) <<< 8);
                acc_reg <= AccW'(90 << 16);
            end else begin
                cx_reg <= VW'(fz_reg) <<< 8;
                cy_reg <= VW'(hres_reg);
                acc_reg <= '0;
            end
        end else if (cmd.cordic_step) begin
            if (cy_reg > 0) begin
                cx_reg <= cx_reg + dy;
                cy_reg <= cy_reg - dx;
                acc_reg <= acc_reg + signed'(tad_pkg::ang_lut(ci_reg));
            end else begin
                cx_reg <= cx_reg - dy;
                cy_reg <= cy_reg + dx;
                acc_reg <= acc_reg - signed'(tad_pkg::ang_lut(ci_reg));
            end
            ci_reg <= ci_reg + 5'd1;
        end
    end

    // Result: leaned, tilt, magnitude, z, y, x from high bits down
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            res_reg <= {zero_reg ? detect_enable : (detect_enable && !in_band),
                        zero_reg ? 8'd0 : 8'(t), mres_reg,
                        az_reg, ay_reg, ax_reg};
        end
    end
    assign result = res_reg;
endmodule

// ----- hdl/tad_checker.sv -----
`timescale 1ns / 1ps
module tad_checker (
    input logic aclk, aresetn, s_tvalid, s_tready, m_tvalid, m_tready,
    input logic [55:0] m_tdata
);
    // no new sample while a previous one is in flight
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("accepted while busy");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata)) else $error("drop");
    a_tilt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[55:48] <= 8'd180)
        else $error("tilt range");
endmodule

bind tilt_angle_detector_core tad_checker u_chk (.*);
